[hdl/tpr_pkg.sv]
// Shared constants and sample rounding functions for the RGBA8 pixel converter.
package tpr_pkg;

    // Palette address bits by default
    localparam int PALETTE_BITS_DEF = 8;

    // Configuration register indexes
    localparam logic [2:0] REG_COLOR_MODEL  = 3'd0;
    localparam logic [2:0] REG_SAMPLE_WIDTH = 3'd1;
    localparam logic [2:0] REG_MIN_IS_WHITE = 3'd2;
    localparam logic [2:0] REG_ALPHA_MODE   = 3'd3;
    localparam logic [2:0] REG_PAL_8BIT     = 3'd4;

    // Color models
    localparam logic [1:0] CM_GREY    = 2'd0;
    localparam logic [1:0] CM_PALETTE = 2'd1;
    localparam logic [1:0] CM_RGB     = 2'd2;
    localparam logic [1:0] CM_CMYK    = 2'd3;

    // Alpha modes
    localparam logic [1:0] AM_NONE     = 2'd0;
    localparam logic [1:0] AM_STRAIGHT = 2'd1;
    localparam logic [1:0] AM_ASSOC    = 2'd2;

    // Sample width codes
    localparam logic [2:0] SW_1  = 3'd0;
    localparam logic [2:0] SW_2  = 3'd1;
    localparam logic [2:0] SW_4  = 3'd2;
    localparam logic [2:0] SW_8  = 3'd3;
    localparam logic [2:0] SW_16 = 3'd4;
    localparam logic [2:0] SW_32 = 3'd5;

    // Round a 16-bit value to 8 bits: (v*255 + 32767) / 65535
    function automatic logic [7:0] scale16(input logic [15:0] v);
        logic [23:0] y;
        logic [24:0] q;
        begin
            y = {v, 8'd0} - 24'(v) + 24'd32767;
            q = 25'(y) + 25'd1 + 25'(y[23:16]);
            scale16 = q[23:16];
        end
    endfunction

    // Round a 32-bit value to 8 bits: (v*255 + 2^31-1) / (2^32-1)
    function automatic logic [7:0] scale32(input logic [31:0] v);
        logic [39:0] y;
        logic [40:0] q;
        begin
            y = {v, 8'd0} - 40'(v) + 40'h007FFFFFFF;
            q = 41'(y) + 41'd1 + 41'(y[39:32]);
            scale32 = q[39:32];
        end
    endfunction

    // Mask a sample to the configured width and round it to 8 bits
    function automatic logic [7:0] round8(input logic [31:0] v, input logic [2:0] code);
        begin
            case (code)
                SW_1:    round8 = v[0] ? 8'd255 : 8'd0;
                SW_2:    round8 = 8'(v[1:0]) * 8'd85;
                SW_4:    round8 = 8'(v[3:0]) * 8'd17;
                SW_16:   round8 = scale16(v[15:0]);
                SW_32:   round8 = scale32(v);
                default: round8 = v[7:0];
            endcase
        end
    endfunction

    // Mask a sample to the configured width
    function automatic logic [31:0] mask_sample(input logic [31:0] v, input logic [2:0] code);
        begin
            case (code)
                SW_1:    mask_sample = {31'd0, v[0]};
                SW_2:    mask_sample = {30'd0, v[1:0]};
                SW_4:    mask_sample = {28'd0, v[3:0]};
                SW_16:   mask_sample = {16'd0, v[15:0]};
                SW_32:   mask_sample = v;
                default: mask_sample = {24'd0, v[7:0]};
            endcase
        end
    endfunction

endpackage

[hdl/tiff_pixel_to_rgba8_core.sv]
// Top level of the pixel to RGBA8 converter.
//
//  Channel | Dir | Beat
//  s_*     | in  | tdata: sample0, sample1, sample2, sample3, alpha_sample, entry_index,
//          |     |        entry_red, entry_green, entry_blue; tuser: cmd
//  m_*     | out | tdata: red, green, blue, alpha; tuser: palette_miss
//  cfg_*   | in  | register index and data, always ready
//
// One beat per clock while the output beat is not stalled.
// The pipeline is round, color, select, then three stages of un-premultiply
// (a radix-2 divider spread over two stages).
// A palette write beat updates the palette RAM and yields no output beat.
// rst_n clears valid bits and configuration; the palette is undefined until written.
// The whole pipeline holds when the output beat is stalled; nothing is lost or repeated.
module tiff_pixel_to_rgba8_core
    import tpr_pkg::*;
#(
    parameter int PALETTE_BITS = PALETTE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [215:0] s_tdata,   // sample0..3, alpha_sample, entry_index, entry_red/green/blue
    input  logic [0:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // red, green, blue, alpha
    output logic [0:0]   m_tuser,   // palette_miss
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [2:0]   cfg_data
);

    localparam int PAL_DEPTH = 1 << PALETTE_BITS;

    logic [1:0] color_model_reg;
    logic [2:0] sample_width_reg;
    logic       min_is_white_reg;
    logic [1:0] alpha_mode_reg;
    logic       pal_8bit_reg;

    logic        en;
    logic        accept;
    logic [31:0] in_s0;
    logic [31:0] in_s1;
    logic [31:0] in_s2;
    logic [31:0] in_s3;
    logic [31:0] in_sa;
    logic [7:0]  in_entry;
    logic [31:0] s0_masked;
    logic        pal_we;
    logic [47:0] pal_rdata;

    logic        v1_reg;
    logic [7:0]  c1_reg [4];
    logic [7:0]  a1_reg;
    logic        miss1_reg;

    logic        v2_reg;
    logic [7:0]  c2_reg [3];
    logic [7:0]  grey2_reg;
    logic [7:0]  pal2_reg [3];
    logic [15:0] ink2_reg [3];
    logic [7:0]  a2_reg;
    logic        miss2_reg;

    logic [7:0]  col3_next [3];
    logic        v3_reg;
    logic [7:0]  col3_reg [3];
    logic [7:0]  a3_reg;
    logic        miss3_reg;

    logic [2:0]  vd_reg;
    logic [7:0]  ad_reg [3];
    logic        missd_reg [3];
    logic [7:0]  col_out [3];

    // Configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_model_reg  <= CM_GREY;
            sample_width_reg <= SW_8;
            min_is_white_reg <= 1'b0;
            alpha_mode_reg   <= AM_NONE;
            pal_8bit_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COLOR_MODEL:  color_model_reg  <= cfg_data[1:0];
                REG_SAMPLE_WIDTH: sample_width_reg <= cfg_data;
                REG_MIN_IS_WHITE: min_is_white_reg <= cfg_data[0];
                REG_ALPHA_MODE:   alpha_mode_reg   <= cfg_data[1:0];
                REG_PAL_8BIT:     pal_8bit_reg     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Advance all stages unless the output beat is stalled
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    assign in_s0    = s_tdata[31:0];
    assign in_s1    = s_tdata[63:32];
    assign in_s2    = s_tdata[95:64];
    assign in_s3    = s_tdata[127:96];
    assign in_sa    = s_tdata[159:128];
    assign in_entry = s_tdata[167:160];

    assign s0_masked = mask_sample(in_s0, sample_width_reg);
    assign pal_we    = accept && s_tuser[0] && ((16'(in_entry) >> PALETTE_BITS) == 16'd0);

    // Palette store
    tpr_ram #(
        .WIDTH (48),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (PALETTE_BITS'(in_entry)),
        .wdata (s_tdata[215:168]),
        .re    (en),
        .raddr (s0_masked[PALETTE_BITS-1:0]),
        .rdata (pal_rdata)
    );

    // Stage 1: round samples to 8 bits, flag palette miss
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= accept && !s_tuser[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg[0] <= round8(in_s0, sample_width_reg);
            c1_reg[1] <= round8(in_s1, sample_width_reg);
            c1_reg[2] <= round8(in_s2, sample_width_reg);
            c1_reg[3] <= round8(in_s3, sample_width_reg);
            if (alpha_mode_reg == AM_STRAIGHT || alpha_mode_reg == AM_ASSOC)
                a1_reg <= round8(in_sa, sample_width_reg);
            else
                a1_reg <= 8'd255;
            miss1_reg <= (s0_masked >> PALETTE_BITS) != 32'd0;
        end
    end

    // Stage 2: grey, palette scaling and ink products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grey2_reg <= min_is_white_reg ? (8'd255 - c1_reg[0]) : c1_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                c2_reg[i]   <= c1_reg[i];
                pal2_reg[i] <= pal_8bit_reg ? pal_rdata[16*i +: 8]
                                            : scale16(pal_rdata[16*i +: 16]);
                ink2_reg[i] <= 16'(8'd255 - c1_reg[i]) * 16'(8'd255 - c1_reg[3]);
            end
            a2_reg    <= a1_reg;
            miss2_reg <= miss1_reg && (color_model_reg == CM_PALETTE);
        end
    end

    // Stage 3: pick the color by model
    always_comb
    begin
        logic [16:0] y;
        logic [16:0] q;
        for (int i = 0; i < 3; i++)
        begin
            y = 17'(ink2_reg[i]) + 17'd127;
            q = y + 17'd1 + 17'(y[16:8]);
            case (color_model_reg)
                CM_GREY:    col3_next[i] = grey2_reg;
                CM_PALETTE: col3_next[i] = miss2_reg ? 8'd0 : pal2_reg[i];
                CM_RGB:     col3_next[i] = c2_reg[i];
                default:    col3_next[i] = q[15:8];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col3_reg  <= col3_next;
            a3_reg    <= a2_reg;
            miss3_reg <= miss2_reg;
        end
    end

    // Stages 4 to 6: un-premultiply each channel
    for (genvar g = 0; g < 3; g++)
    begin : g_unassoc
        tpr_unassoc u_unassoc (
            .clk       (clk),
            .en        (en),
            .color_in  (col3_reg[g]),
            .alpha_in  (a3_reg),
            .assoc     (alpha_mode_reg == AM_ASSOC),
            .color_out (col_out[g])
        );
    end

    // Carry valid, alpha and miss alongside the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 3'd0;
        else if (en)
            vd_reg <= {vd_reg[1:0], v3_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad_reg[0]    <= a3_reg;
            ad_reg[1]    <= ad_reg[0];
            ad_reg[2]    <= ad_reg[1];
            missd_reg[0] <= miss3_reg;
            missd_reg[1] <= missd_reg[0];
            missd_reg[2] <= missd_reg[1];
        end
    end

    assign m_tvalid = vd_reg[2];
    assign m_tdata  = {ad_reg[2], col_out[2], col_out[1], col_out[0]};
    assign m_tuser  = missd_reg[2];

`ifndef SYNTHESIS
    a_miss_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[23:0] == 24'd0)
        else $error("palette miss with nonzero color");

    a_miss_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> color_model_reg == CM_PALETTE)
        else $error("palette miss outside palette mode");

    a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (alpha_mode_reg == AM_NONE || alpha_mode_reg == 2'd3)
        |-> m_tdata[31:24] == 8'd255)
        else $error("alpha not opaque with no alpha mode");

    a_write_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tuser[0] |=> !v1_reg)
        else $error("palette write produced a pixel");
`endif

endmodule

[hdl/tpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tpr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/tpr_unassoc.sv]
// Three-stage un-premultiply of one color channel with saturation at 255.
module tpr_unassoc
    import tpr_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] color_in,
    input  logic [7:0] alpha_in,
    input  logic       assoc,
    output logic [7:0] color_out
);

    logic [15:0] num_next;
    logic        sat_next;
    logic [15:0] num_reg;
    logic [7:0]  den_reg;
    logic        sat_reg;
    logic        zero_reg;
    logic        pass_reg;
    logic [7:0]  color_a_reg;

    logic [15:0] rem_next;
    logic [3:0]  qhi_next;
    logic [15:0] rem_reg;
    logic [3:0]  qhi_reg;
    logic [7:0]  den_b_reg;
    logic        sat_b_reg;
    logic        zero_b_reg;
    logic        pass_b_reg;
    logic [7:0]  color_b_reg;

    logic [3:0]  qlo_next;
    logic [7:0]  out_next;
    logic [7:0]  out_reg;

    // Numerator c*255 + a/2, saturate when quotient would pass 255
    always_comb
    begin
        num_next = {color_in, 8'd0} - 16'(color_in) + 16'(alpha_in[7:1]);
        sat_next = 17'(num_next) >= {1'b0, alpha_in, 8'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg     <= num_next;
            den_reg     <= alpha_in;
            sat_reg     <= sat_next;
            zero_reg    <= (alpha_in == 8'd0);
            pass_reg    <= !assoc;
            color_a_reg <= color_in;
        end
    end

    // Upper four quotient bits
    always_comb
    begin
        rem_next = num_reg;
        qhi_next = 4'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (rem_next >= (16'(den_reg) << (i + 4)))
            begin
                rem_next    = rem_next - (16'(den_reg) << (i + 4));
                qhi_next[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg     <= rem_next;
            qhi_reg     <= qhi_next;
            den_b_reg   <= den_reg;
            sat_b_reg   <= sat_reg;
            zero_b_reg  <= zero_reg;
            pass_b_reg  <= pass_reg;
            color_b_reg <= color_a_reg;
        end
    end

    // Lower four quotient bits and final pick
    always_comb
    begin
        logic [15:0] rem;
        rem      = rem_reg;
        qlo_next = 4'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (rem >= (16'(den_b_reg) << i))
            begin
                rem         = rem - (16'(den_b_reg) << i);
                qlo_next[i] = 1'b1;
            end
        end
        if (pass_b_reg)
            out_next = color_b_reg;
        else if (zero_b_reg)
            out_next = 8'd0;
        else if (sat_b_reg)
            out_next = 8'd255;
        else
            out_next = {qhi_reg, qlo_next};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign color_out = out_reg;

endmodule

[tb/tiff_pixel_to_rgba8_core_tb.sv]
// Self-checking testbench for the pixel to RGBA8 converter.
`timescale 1ns / 1ps

module tiff_pixel_to_rgba8_core_tb;
    import tpr_pkg::*;

    localparam int PAL_DEPTH = 1 << PALETTE_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [1:0] cm;
        logic [2:0] sw;
        logic       miw;
        logic [1:0] am;
        logic       p8;
    } cfg_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       miss;
    } pix_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
        logic [31:0] al;
        logic [7:0]  eidx;
        logic [15:0] er;
        logic [15:0] eg;
        logic [15:0] eb;
    } beat_t;

    typedef struct packed {
        cfg_t  cfg;
        beat_t bt;
        logic  typed;
        pix_t  res;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [215:0] s_tdata;    // sample0..3, alpha_sample, entry_index, entry_red/green/blue
    logic [0:0]   s_tuser;    // cmd
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;    // red, green, blue, alpha
    logic [0:0]   m_tuser;    // palette_miss
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [2:0]   cfg_data;

    cfg_t        conv_cfg;
    logic [15:0] pal_red [PAL_DEPTH];
    logic [15:0] pal_green [PAL_DEPTH];
    logic [15:0] pal_blue [PAL_DEPTH];
    pix_t        pending_pix[$];
    int          send_idle;
    int          recv_idle;
    int          mismatches;
    int          cycles;
    row_t        dir_tab[16];

    tiff_pixel_to_rgba8_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int bits_of(input logic [2:0] code);
        case (code)
            SW_1:    return 1;
            SW_2:    return 2;
            SW_4:    return 4;
            SW_16:   return 16;
            SW_32:   return 32;
            default: return 8;
        endcase
    endfunction

    function automatic logic [31:0] keep_bits(input logic [31:0] v, input int bits);
        logic [63:0] m;
        m = (64'd1 << bits) - 64'd1;
        return v & m[31:0];
    endfunction

    // Scale a masked sample of the given width to 8 bits with rounding
    function automatic logic [7:0] to_byte(input logic [31:0] v, input int bits);
        logic [63:0] x;
        logic [63:0] m;
        x = {32'd0, keep_bits(v, bits)};
        m = (64'd1 << bits) - 64'd1;
        if (bits == 8)
            return x[7:0];
        return 8'((x * 64'd255 + m / 64'd2) / m);
    endfunction

    function automatic logic [7:0] entry_byte(input logic [15:0] v);
        if (conv_cfg.p8)
            return v[7:0];
        return 8'((32'(v) * 32'd255 + 32'd32767) / 32'd65535);
    endfunction

    function automatic logic [7:0] unpremultiply(input logic [7:0] c, input logic [7:0] a);
        logic [31:0] q;
        if (a == 8'd0)
            return 8'd0;
        q = (32'(c) * 32'd255 + 32'(a) / 32'd2) / 32'(a);
        return (q > 32'd255) ? 8'd255 : q[7:0];
    endfunction

    function automatic logic [7:0] ink_out(input logic [31:0] s, input int bits,
                                           input logic [31:0] k);
        logic [31:0] c;
        c = 32'd255 - 32'(to_byte(s, bits));
        return 8'((c * k + 32'd127) / 32'd255);
    endfunction

    // Expected RGBA8 pixel for one convert beat under the current settings
    function automatic pix_t convert_pixel(input beat_t bt);
        pix_t        p;
        int          bits;
        logic [31:0] k;
        logic [31:0] idx;
        bits = bits_of(conv_cfg.sw);
        p = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255, miss: 1'b0};
        case (conv_cfg.cm)
            CM_GREY:
            begin
                p.r = to_byte(bt.s0, bits);
                if (conv_cfg.miw)
                    p.r = 8'd255 - p.r;
                p.g = p.r;
                p.b = p.r;
            end
            CM_PALETTE:
            begin
                idx = keep_bits(bt.s0, bits);
                if (idx >= PAL_DEPTH)
                    p.miss = 1'b1;
                else
                begin
                    p.r = entry_byte(pal_red[idx]);
                    p.g = entry_byte(pal_green[idx]);
                    p.b = entry_byte(pal_blue[idx]);
                end
            end
            CM_RGB:
            begin
                p.r = to_byte(bt.s0, bits);
                p.g = to_byte(bt.s1, bits);
                p.b = to_byte(bt.s2, bits);
            end
            default:
            begin
                k = 32'd255 - 32'(to_byte(bt.s3, bits));
                p.r = ink_out(bt.s0, bits, k);
                p.g = ink_out(bt.s1, bits, k);
                p.b = ink_out(bt.s2, bits, k);
            end
        endcase
        if (conv_cfg.am == AM_STRAIGHT || conv_cfg.am == AM_ASSOC)
        begin
            p.a = to_byte(bt.al, bits);
            if (conv_cfg.am == AM_ASSOC)
            begin
                p.r = unpremultiply(p.r, p.a);
                p.g = unpremultiply(p.g, p.a);
                p.b = unpremultiply(p.b, p.a);
            end
        end
        return p;
    endfunction

    // Drive one beat, wait for its handshake, record the effect, then idle at random
    task automatic send_beat(input beat_t bt, input logic typed, input pix_t res);
        s_tvalid <= 1'b1;
        s_tuser <= bt.cmd;
        s_tdata <= {bt.eb, bt.eg, bt.er, bt.eidx, bt.al, bt.s3, bt.s2, bt.s1, bt.s0};
        do @(posedge clk); while (!s_tready);
        if (bt.cmd)
        begin
            pal_red[bt.eidx] = bt.er;
            pal_green[bt.eidx] = bt.eg;
            pal_blue[bt.eidx] = bt.eb;
        end
        else
            pending_pix.push_back(typed ? res : convert_pixel(bt));
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Hold the input idle until every pixel is out and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pix.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five registers in one burst
    task automatic load_cfg(input cfg_t c);
        logic [2:0] vals[5];
        logic [2:0] regs[5];
        regs = '{REG_COLOR_MODEL, REG_SAMPLE_WIDTH, REG_MIN_IS_WHITE, REG_ALPHA_MODE,
                 REG_PAL_8BIT};
        vals = '{3'(c.cm), c.sw, 3'(c.miw), 3'(c.am), 3'(c.p8)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        conv_cfg = c;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    function automatic beat_t rand_beat();
        beat_t bt;
        bt.cmd = ($urandom_range(9) == 0);
        bt.s0 = rand_sample();
        bt.s1 = rand_sample();
        bt.s2 = rand_sample();
        bt.s3 = rand_sample();
        bt.al = rand_sample();
        // Keep palette lookups in range most of the time
        if (conv_cfg.cm == CM_PALETTE && $urandom_range(2) != 0)
        begin
            bt.s0[15:0] = 16'($urandom_range(PAL_DEPTH - 1));
            if ($urandom_range(1))
                bt.s0[31:16] = 16'd0;
        end
        bt.eidx = 8'($urandom);
        bt.er = 16'($urandom);
        bt.eg = 16'($urandom);
        bt.eb = 16'($urandom);
        return bt;
    endfunction

    // Check each output beat against the oldest expected pixel
    always @(posedge clk or negedge rst_n)
    begin
        pix_t want;
        pix_t got;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{r: m_tdata[7:0], g: m_tdata[15:8], b: m_tdata[23:16],
                        a: m_tdata[31:24], miss: m_tuser[0]};
                if (pending_pix.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel r=%0h g=%0h b=%0h a=%0h miss=%0b",
                                 got.r, got.g, got.b, got.a, got.miss);
                end
                else
                begin
                    want = pending_pix.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("pixel mismatch: want r=%0h g=%0h b=%0h a=%0h miss=%0b",
                                     want.r, want.g, want.b, want.a, want.miss);
                            $display("                got  r=%0h g=%0h b=%0h a=%0h miss=%0b",
                                     got.r, got.g, got.b, got.a, got.miss);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        beat_t bt;
        cfg_t  c;
        pix_t  none;
        none = '0;
        cycles = 0;
        mismatches = 0;
        send_idle = 0;
        recv_idle = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        conv_cfg = '{cm: CM_GREY, sw: SW_8, miw: 1'b0, am: AM_NONE, p8: 1'b0};

        // Directed rows: settings, beat, and a typed result where obvious
        dir_tab[0] = '{'{CM_GREY, SW_8, 1'b0, AM_NONE, 1'b0},
                       '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0, 16'd0},
                       1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b0}};
        dir_tab[1] = '{'{CM_GREY, SW_8, 1'b0, AM_NONE, 1'b0},
                       '{1'b0, 32'hFF, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 8'd0, 16'd0,
                         16'd0, 16'd0},
                       1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}};
        dir_tab[2] = '{'{CM_GREY, SW_8, 1'b0, AM_NONE, 1'b0},
                       '{1'b0, 32'hFFFF_FF80, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 16'd0,
                         16'd0, 16'd0},
                       1'b1, '{8'h80, 8'h80, 8'h80, 8'hFF, 1'b0}};
        dir_tab[3] = '{'{CM_GREY, SW_1, 1'b1, AM_NONE, 1'b0},
                       '{1'b0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0, 16'd0},
                       1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b0}};
        dir_tab[4] = '{'{CM_PALETTE, SW_16, 1'b0, AM_NONE, 1'b1},
                       '{1'b0, 32'h100, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0,
                         16'd0},
                       1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1}};
        dir_tab[5] = '{'{CM_PALETTE, SW_16, 1'b0, AM_NONE, 1'b1},
                       '{1'b0, 32'hFFFF_0005, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 16'd0,
                         16'd0, 16'd0},
                       1'b0, none};
        dir_tab[6] = '{'{CM_PALETTE, SW_16, 1'b0, AM_NONE, 1'b1},
                       '{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'hFF, 16'hFFFF,
                         16'h1234, 16'h00FF},
                       1'b0, none};
        dir_tab[7] = '{'{CM_PALETTE, SW_32, 1'b0, AM_STRAIGHT, 1'b0},
                       '{1'b0, 32'hFF, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 8'd0, 16'd0,
                         16'd0, 16'd0},
                       1'b0, none};
        dir_tab[8] = '{'{CM_RGB, SW_32, 1'b0, AM_ASSOC, 1'b0},
                       '{1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 32'd0, 32'd0, 8'd0,
                         16'd0, 16'd0, 16'd0},
                       1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}};
        dir_tab[9] = '{'{CM_RGB, SW_32, 1'b0, AM_ASSOC, 1'b0},
                       '{1'b0, 32'hFFFF_FFFF, 32'h4000_0000, 32'h0100_0000, 32'd0,
                         32'h0200_0000, 8'd0, 16'd0, 16'd0, 16'd0},
                       1'b0, none};
        dir_tab[10] = '{'{CM_CMYK, SW_8, 1'b0, AM_STRAIGHT, 1'b0},
                        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h80, 8'd0, 16'd0, 16'd0,
                          16'd0},
                        1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'h80, 1'b0}};
        dir_tab[11] = '{'{CM_CMYK, SW_8, 1'b0, AM_STRAIGHT, 1'b0},
                        '{1'b0, 32'h12, 32'h34, 32'h56, 32'hFF, 32'h80, 8'd0, 16'd0,
                          16'd0, 16'd0},
                        1'b1, '{8'h00, 8'h00, 8'h00, 8'h80, 1'b0}};
        dir_tab[12] = '{'{CM_RGB, 3'd6, 1'b0, 2'd3, 1'b0},
                        '{1'b0, 32'h1FF, 32'h77, 32'hAB00, 32'd0, 32'h10, 8'd0, 16'd0,
                          16'd0, 16'd0},
                        1'b0, none};
        dir_tab[13] = '{'{CM_RGB, 3'd7, 1'b1, AM_NONE, 1'b0},
                        '{1'b0, 32'h3C, 32'hFFFF_FF01, 32'h80, 32'd0, 32'd0, 8'd0, 16'd0,
                          16'd0, 16'd0},
                        1'b0, none};
        dir_tab[14] = '{'{CM_CMYK, SW_2, 1'b0, AM_ASSOC, 1'b0},
                        '{1'b0, 32'd1, 32'd2, 32'd3, 32'd1, 32'd2, 8'd0, 16'd0, 16'd0,
                          16'd0},
                        1'b0, none};
        dir_tab[15] = '{'{CM_GREY, SW_4, 1'b1, AM_ASSOC, 1'b1},
                        '{1'b0, 32'h7, 32'd0, 32'd0, 32'd0, 32'h9, 8'd0, 16'd0, 16'd0,
                          16'd0},
                        1'b0, none};

        // Reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole palette so no lookup hits an unwritten entry
        for (int i = 0; i < PAL_DEPTH; i++)
        begin
            bt = rand_beat();
            bt.cmd = 1'b1;
            bt.eidx = 8'(i);
            if (i == 0)
                {bt.er, bt.eg, bt.eb} = '0;
            if (i == PAL_DEPTH - 1)
                {bt.er, bt.eg, bt.eb} = '1;
            send_beat(bt, 1'b0, none);
        end
        drain();

        // Directed rows; the reset settings apply until a row asks otherwise
        for (int i = 0; i < 16; i++)
        begin
            if (dir_tab[i].cfg != conv_cfg || i == 0)
            begin
                drain();
                load_cfg(dir_tab[i].cfg);
            end
            send_beat(dir_tab[i].bt, dir_tab[i].typed, dir_tab[i].res);
        end

        // Random phases: each with its own settings and one of three idle mixes
        for (int ph = 0; ph < 14; ph++)
        begin
            drain();
            if (ph == 0)
                c = '{cm: CM_GREY, sw: SW_1, miw: 1'b0, am: AM_NONE, p8: 1'b0};
            else if (ph == 1)
                c = '{cm: CM_CMYK, sw: SW_32, miw: 1'b1, am: AM_ASSOC, p8: 1'b1};
            else
                c = '{cm: 2'($urandom_range(3)), sw: 3'($urandom_range(7)),
                      miw: 1'($urandom), am: 2'($urandom_range(3)), p8: 1'($urandom)};
            load_cfg(c);
            if (ph < 5)
            begin
                send_idle = 35;
                recv_idle = 65;
            end
            else if (ph < 10)
            begin
                send_idle = 65;
                recv_idle = 35;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int n = 0; n < 80; n++)
                send_beat(rand_beat(), 1'b0, none);
        end
        drain();

        if (mismatches == 0 && pending_pix.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
